// ----- rtl/wg_pkg.sv -----
// shared types, constants and the sine table builder of the waveform generator
// no dependencies
`default_nettype none

package wg_pkg;

  localparam int PHASE_BITS_DEFAULT     = 32;
  localparam int SINE_ADDR_BITS_DEFAULT = 10;
  localparam int SAMPLE_BITS_DEFAULT    = 16;

  localparam int AMP_BITS       = 15;
  localparam int STEP_BITS      = 32;
  localparam int FRAC_BITS      = 32;
  localparam int ENTRY_BITS     = 15;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam int FULL_SCALE = 32767;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAWTOOTH = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_PULSE    = 3'd4
  } wg_wave_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WAVE_SELECT = 2'd0,
    CFG_AMPLITUDE   = 2'd1,
    CFG_PHASE_STEP  = 2'd2
  } wg_cfg_index_t;

  typedef struct packed {
    wg_wave_t              wave_sel;
    logic [AMP_BITS-1:0]   amplitude;
    logic [STEP_BITS-1:0]  phase_step;
  } wg_cfg_t;

  // what the accumulator hands to the pipeline for one tick
  typedef struct packed {
    logic [FRAC_BITS-1:0] frac;
    logic                 pulse;
  } wg_tap_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // taylor divisors (2n)(2n+1)
  localparam longint unsigned TAYLOR_DIV [11] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506
  };

  // one quarter-wave entry, evaluated at elaboration only
  function automatic logic [ENTRY_BITS-1:0] sine_entry(int k, int addr_bits);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint          sum;
    longint          r;
    th   = (HALF_PI_Q30 * longint'(k)) >> addr_bits;
    th2  = (th * th) >> 30;
    term = th;
    sum  = longint'(th);
    for (int n = 1; n < 12; n++) begin
      term = ((term * th2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum * FULL_SCALE + (longint'(1) << 29)) >>> 30;
    if (r > FULL_SCALE) r = FULL_SCALE;
    return r[ENTRY_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wg_tick_if.sv -----
// tick channel: valid/ready handshake carrying the restart flag
// no dependencies
`default_nettype none

interface wg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ----- rtl/wg_sample_if.sv -----
// sample channel: valid/ready handshake carrying one signed sample
// no dependencies
`default_nettype none

interface wg_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/waveform_generator.sv -----
// waveform generator top level: configuration registers, phase accumulator
// and sample pipeline; depends on wg_pkg, wg_tick_if, wg_sample_if and submodules
//
// usage
//   - every beat on the tick channel yields exactly one beat on the sample
//     channel, in order; restart set on a tick zeroes the phase before that
//     sample is taken
//   - wave_select, amplitude and phase_step are written through the plain
//     write port (cfg_we, cfg_index, cfg_data) while no tick is in flight
//   - a sample passes, after its tick is taken, through the fraction
//     register, sine rom read, shaping and output register
//   - throughput: one tick per cycle while the sample channel is ready; the
//     phase add and pulse compare in the accumulator close within the accept cycle
//   - a stalled sample channel holds the output register; bubbles further
//     back still fill, so ticks keep being taken until every stage is full
//   - reset clears the phase, the configuration and all stage valid bits;
//     the sine table is a constant rom, so there is no fill pass after reset
`default_nettype none

module waveform_generator
  import wg_pkg::*;
#(
  parameter int PHASE_BITS           = PHASE_BITS_DEFAULT,
  parameter int SINE_TABLE_ADDR_BITS = SINE_ADDR_BITS_DEFAULT,
  parameter int SAMPLE_BITS          = SAMPLE_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  wg_tick_if.sink                        tick,
  wg_sample_if.source                    samples,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  wg_cfg_t cfg;
  wg_tap_t tap;
  logic    tick_ready;
  logic    tick_accept;

  // configuration registers; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_sel   <= WAVE_SINE;
      cfg.amplitude  <= '0;
      cfg.phase_step <= '0;
    end else if (cfg_we) begin
      case (wg_cfg_index_t'(cfg_index))
        CFG_WAVE_SELECT: cfg.wave_sel   <= wg_wave_t'(cfg_data[2:0]);
        CFG_AMPLITUDE:   cfg.amplitude  <= cfg_data[AMP_BITS-1:0];
        CFG_PHASE_STEP:  cfg.phase_step <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign tick.ready  = tick_ready;
  assign tick_accept = tick.valid && tick_ready;

  // phase seen by this tick, then advanced by the aligned step
  wg_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (tick_accept),
    .restart (tick.restart),
    .tap     (tap)
  );

  // shaping pipeline with a per-stage ready chain back from the output beat
  wg_datapath #(
    .SINE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (tick.valid),
    .in_ready (tick_ready),
    .tap      (tap),
    .samples  (samples)
  );

endmodule

`default_nettype wire

// ----- rtl/wg_phase_acc.sv -----
// phase accumulator: restart, step alignment, pulse compare and q0.32 fraction
// depends on wg_pkg
`default_nettype none

module wg_phase_acc
  import wg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire wg_cfg_t cfg,
  input  wire logic    accept,
  input  wire logic    restart,
  output wg_tap_t      tap
);

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] step_al;

  assign phase_cur = restart ? '0 : phase;

  if (PHASE_BITS >= STEP_BITS) begin : g_wide
    assign step_al  = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - STEP_BITS);
    assign tap.frac = FRAC_BITS'(phase_cur >> (PHASE_BITS - FRAC_BITS));
  end else begin : g_narrow
    assign step_al  = PHASE_BITS'(cfg.phase_step >> (STEP_BITS - PHASE_BITS));
    assign tap.frac = FRAC_BITS'(phase_cur) << (FRAC_BITS - PHASE_BITS);
  end

  assign tap.pulse  = phase_cur < step_al;
  assign phase_next = phase_cur + step_al;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wg_sine_rom.sv -----
// quarter-wave sine rom, 2^ADDR_BITS + 1 entries in unsigned q0.15, registered read
// depends on wg_pkg
`default_nettype none

module wg_sine_rom
  import wg_pkg::*;
#(
  parameter int ADDR_BITS = SINE_ADDR_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ADDR_BITS:0]    addr,
  output logic      [ENTRY_BITS-1:0] data
);

  localparam int DEPTH = (1 << ADDR_BITS) + 1;

  typedef logic [ENTRY_BITS-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = sine_entry(k, ADDR_BITS);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wg_datapath.sv -----
// four-stage sample pipeline: rom address and products, shaping, scaling,
// saturation into the output register; depends on wg_pkg, wg_sine_rom, wg_sample_if
`default_nettype none

module wg_datapath
  import wg_pkg::*;
#(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEFAULT,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire wg_cfg_t cfg,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire wg_tap_t tap,
  wg_sample_if.source  samples
);

  localparam int TBL_N    = 1 << SINE_ADDR_BITS;
  localparam int AF_BITS  = AMP_BITS + FRAC_BITS;
  localparam int Y_BITS   = AF_BITS + 4;
  localparam int VAL_BITS = AMP_BITS + 2;
  localparam int VW       = (SAMPLE_BITS > VAL_BITS) ? SAMPLE_BITS : VAL_BITS;
  localparam logic signed [VW-1:0] SAT_HI =
    VW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);
  localparam logic signed [Y_BITS-1:0] TRUNC_BIAS =
    Y_BITS'((longint'(1) << FRAC_BITS) - 1);

  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;

  // stage 1
  logic [FRAC_BITS-1:0] f1;
  logic                 pul1;
  // stage 2
  logic [AF_BITS-1:0]   af2;
  logic [1:0]           quad2;
  logic                 pul2;
  logic [ENTRY_BITS-1:0] rom_q;
  // stage 3
  logic [2*AMP_BITS-1:0]       ta3;
  logic                        neg3;
  logic signed [VAL_BITS-1:0]  alt3;
  // stage 4
  logic signed [SAMPLE_BITS-1:0] sample_q;

  assign en4      = !v4 || samples.ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1 -> 2: mirrored rom address, amplitude times fraction
  logic [SINE_ADDR_BITS-1:0] idx1;
  logic [SINE_ADDR_BITS:0]   addr1;
  logic [AF_BITS-1:0]        af1;

  assign idx1  = f1[FRAC_BITS-3 -: SINE_ADDR_BITS];
  assign addr1 = f1[FRAC_BITS-2] ? ((SINE_ADDR_BITS+1)'(TBL_N) - {1'b0, idx1})
                                 : {1'b0, idx1};
  assign af1   = AF_BITS'(cfg.amplitude) * AF_BITS'(f1);

  wg_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (en2),
    .addr (addr1),
    .data (rom_q)
  );

  // stage 2 -> 3: linear shapes truncated toward zero, sine product
  logic signed [Y_BITS-1:0]   a_one;
  logic signed [Y_BITS-1:0]   x1s;
  logic signed [Y_BITS-1:0]   x2s;
  logic signed [Y_BITS-1:0]   tri_y;
  logic signed [Y_BITS-1:0]   saw_y;
  logic signed [Y_BITS-1:0]   lin_y;
  logic signed [Y_BITS-1:0]   lin_adj;
  logic signed [VAL_BITS-1:0] lin_v;
  logic signed [VAL_BITS-1:0] amp_v;
  logic signed [VAL_BITS-1:0] alt_v;
  logic [2*AMP_BITS-1:0]      ta2;

  assign a_one = signed'(Y_BITS'(cfg.amplitude) << FRAC_BITS);
  assign x1s   = signed'(Y_BITS'(af2) << 1);
  assign x2s   = signed'(Y_BITS'(af2) << 2);
  // rising half below one half of the period, falling half after it
  assign tri_y = quad2[1] ? ((a_one <<< 1) + a_one - x2s) : (x2s - a_one);
  assign saw_y = x1s - a_one;
  assign lin_y = (cfg.wave_sel == WAVE_TRIANGLE) ? tri_y : saw_y;
  assign lin_adj = lin_y + (lin_y[Y_BITS-1] ? TRUNC_BIAS : '0);
  assign lin_v   = lin_adj[FRAC_BITS+VAL_BITS-1:FRAC_BITS];
  assign amp_v   = signed'(VAL_BITS'(cfg.amplitude));
  assign ta2     = (2*AMP_BITS)'(rom_q) * (2*AMP_BITS)'(cfg.amplitude);

  always_comb begin
    case (cfg.wave_sel)
      WAVE_TRIANGLE: alt_v = lin_v;
      WAVE_SAWTOOTH: alt_v = lin_v;
      WAVE_SQUARE:   alt_v = quad2[1] ? -amp_v : amp_v;
      WAVE_PULSE:    alt_v = pul2 ? amp_v : '0;
      default:       alt_v = '0;
    endcase
  end

  // stage 3 -> 4: divide by full scale, sign by quadrant, saturate
  logic [AMP_BITS-1:0]        q0;
  logic [AMP_BITS:0]          rem;
  logic [AMP_BITS:0]          mag;
  logic signed [VAL_BITS-1:0] sine_v;
  logic signed [VAL_BITS-1:0] val;
  logic signed [VW-1:0]       val_w;
  logic signed [VW-1:0]       sat;

  // 32767 = 2^15 - 1, so the remainder after the shift is low part plus quotient
  assign q0  = ta3[2*AMP_BITS-1:AMP_BITS];
  assign rem = {1'b0, ta3[AMP_BITS-1:0]} + {1'b0, q0};
  assign mag = {1'b0, q0} + (AMP_BITS+1)'(rem >= (AMP_BITS+1)'(FULL_SCALE));
  assign sine_v = neg3 ? -signed'(VAL_BITS'(mag)) : signed'(VAL_BITS'(mag));
  assign val    = (cfg.wave_sel == WAVE_SINE) ? sine_v : alt3;
  assign val_w  = VW'(val);

  always_comb begin
    if (val_w > SAT_HI)      sat = SAT_HI;
    else if (val_w < SAT_LO) sat = SAT_LO;
    else                     sat = val_w;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      f1   <= tap.frac;
      pul1 <= tap.pulse;
    end
    if (en2) begin
      af2   <= af1;
      quad2 <= f1[FRAC_BITS-1:FRAC_BITS-2];
      pul2  <= pul1;
    end
    if (en3) begin
      ta3  <= ta2;
      neg3 <= quad2[1];
      alt3 <= alt_v;
    end
    if (en4) begin
      sample_q <= SAMPLE_BITS'(sat);
    end
  end

  assign samples.valid  = v4;
  assign samples.sample = sample_q;

endmodule

`default_nettype wire
